[hw/rtl/connector_graph_cycle_detector_unit_assert.svh]
// Assertion macros for the connector graph cycle detector.
// Depends on nothing; used by the top level, which provides clk and arst_n.
`ifndef CONNECTOR_GRAPH_CYCLE_DETECTOR_UNIT_ASSERT_SVH
`define CONNECTOR_GRAPH_CYCLE_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CGCD_ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("cgcd: same-cycle implication failed");
`define CGCD_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("cgcd: next-cycle implication failed");
`else
`define CGCD_ASSERT_IMP(lbl, ant, cons)
`define CGCD_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

[hw/rtl/cgcd_pkg.sv]
// Package for the connector graph cycle detector: state and command types.
// Depends on nothing.
`timescale 1ns / 1ps
package cgcd_pkg;
	localparam int unsigned CONN_W = 6;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD_RD, ST_LOAD_WR, ST_ROOT, ST_ROW, ST_SCAN,
		ST_POP_RD, ST_POP_LD, ST_DONE
	} cgcd_state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_CAPTURE, CMD_LOAD_RD, CMD_LOAD_WR, CMD_SKIP_CONN,
		CMD_ROOT_NEXT, CMD_ROOT_PUSH, CMD_ROW_LOAD, CMD_SCAN_NEXT, CMD_PUSH,
		CMD_RETIRE, CMD_POP_RD, CMD_POP_LOAD, CMD_FOUND, CMD_RESULT
	} cgcd_cmd_t;

	typedef struct packed {
		cgcd_cmd_t cmd;
	} cgcd_ctrl_t;

	typedef struct packed {
		logic present;
		logic last_conn;
		logic last_sq;
		logic root_done;
		logic root_colored;
		logic v_end;
		logic edge_bit;
		logic v_grey;
		logic v_white;
		logic stack_full;
		logic sp_one;
		logic out_busy;
	} cgcd_status_t;
endpackage

[hw/rtl/cgcd_sq_if.sv]
// Item channels of the cycle detector: squares in, answers out.
// Depends on cgcd_pkg.
`timescale 1ns / 1ps
interface cgcd_sq_if import cgcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [CONN_W-1:0] connector_a;
	logic [CONN_W-1:0] connector_b;
	logic [CONN_W-1:0] connector_c;
	logic [CONN_W-1:0] connector_d;
	logic last_square;
	modport source (output valid, connector_a, connector_b, connector_c, connector_d,
		last_square, input ready);
	modport sink (input valid, connector_a, connector_b, connector_c, connector_d,
		last_square, output ready);
endinterface

interface cgcd_res_if;
	logic valid;
	logic ready;
	logic has_cycle;
	modport source (output valid, has_cycle, input ready);
	modport sink (input valid, has_cycle, output ready);
endinterface

[hw/rtl/cgcd_ctrl.sv]
// Controller of the cycle detector: sequences loading and the depth-first search.
// Depends on cgcd_pkg.
`timescale 1ns / 1ps
module cgcd_ctrl import cgcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  cgcd_status_t stat,
	output cgcd_ctrl_t   ctrl
);
	cgcd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl.cmd = CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.cmd = CMD_CAPTURE;
					state_d = ST_LOAD_RD;
				end
			end
			ST_LOAD_RD: begin
				if (stat.present) begin
					ctrl.cmd = CMD_LOAD_RD;
					state_d = ST_LOAD_WR;
				end else if (stat.last_conn) begin
					state_d = stat.last_sq ? ST_ROOT : ST_IDLE;
				end else begin
					ctrl.cmd = CMD_SKIP_CONN;
				end
			end
			ST_LOAD_WR: begin
				ctrl.cmd = CMD_LOAD_WR;
				if (stat.last_conn) begin
					state_d = stat.last_sq ? ST_ROOT : ST_IDLE;
				end else begin
					state_d = ST_LOAD_RD;
				end
			end
			ST_ROOT: begin
				if (stat.root_done) begin
					state_d = ST_DONE;
				end else if (stat.root_colored) begin
					ctrl.cmd = CMD_ROOT_NEXT;
				end else begin
					ctrl.cmd = CMD_ROOT_PUSH;
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				ctrl.cmd = CMD_ROW_LOAD;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.v_end) begin
					ctrl.cmd = CMD_RETIRE;
					state_d = stat.sp_one ? ST_ROOT : ST_POP_RD;
				end else if (stat.edge_bit && stat.v_grey) begin
					ctrl.cmd = CMD_FOUND;
					state_d = ST_DONE;
				end else if (stat.edge_bit && stat.v_white && !stat.stack_full) begin
					ctrl.cmd = CMD_PUSH;
					state_d = ST_ROW;
				end else begin
					ctrl.cmd = CMD_SCAN_NEXT;
				end
			end
			ST_POP_RD: begin
				ctrl.cmd = CMD_POP_RD;
				state_d = ST_POP_LD;
			end
			ST_POP_LD: begin
				ctrl.cmd = CMD_POP_LOAD;
				state_d = ST_SCAN;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					ctrl.cmd = CMD_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

[hw/rtl/cgcd_dp.sv]
// Datapath of the cycle detector: adjacency memory, node colors, search stack.
// Depends on cgcd_pkg.
`timescale 1ns / 1ps
module cgcd_dp import cgcd_pkg::*; #(
	parameter int unsigned NODE_COUNT            = 52,
	parameter int unsigned CONNECTORS_PER_SQUARE = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [CONN_W-1:0] conn_in [CONNECTORS_PER_SQUARE],
	input  logic         last_in,
	input  cgcd_ctrl_t   ctrl,
	output cgcd_status_t stat,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         out_bit
);
	localparam int unsigned NW = $clog2(NODE_COUNT);
	localparam int unsigned VW = $clog2(NODE_COUNT + 1);
	localparam int unsigned IW = $clog2(CONNECTORS_PER_SQUARE);

	logic [CONN_W-1:0] conn_q [CONNECTORS_PER_SQUARE];
	logic last_q;
	logic [IW-1:0] idx_q;
	logic [VW-1:0] root_q, v_q, sp_q;
	logic [NW-1:0] u_q;
	logic [NODE_COUNT-1:0] row_q, grey_q, black_q, row_vld_q;
	logic found_q, out_vld_q, out_bit_q;

	logic [NODE_COUNT-1:0] adj_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] adj_rd_q;
	logic adj_rvld_q;
	logic [NW-1:0] stk_mem [NODE_COUNT];
	logic [NW-1:0] stk_rd_q;
	logic [VW-1:0] nn_mem [NODE_COUNT];
	logic [VW-1:0] nn_rd_q;

	logic [CONNECTORS_PER_SQUARE-1:0] pres;
	logic [NW-1:0] node [CONNECTORS_PER_SQUARE];
	logic [NODE_COUNT-1:0] mask, adj_row;
	logic [NW-1:0] adj_raddr, v_n, root_n;
	logic adj_re;

	always_comb begin
		logic [NW-1:0] t;
		mask = '0;
		for (int k = 0; k < CONNECTORS_PER_SQUARE; k++) begin
			pres[k] = (conn_q[k] != '0) && ({1'b0, conn_q[k]} <= (CONN_W + 1)'(NODE_COUNT));
			node[k] = NW'(conn_q[k] - CONN_W'(1));
		end
		for (int k = 0; k < CONNECTORS_PER_SQUARE; k++) begin
			t = node[k] ^ NW'(1);
			if (pres[k] && (IW'(k) != idx_q) && ({1'b0, t} < (NW + 1)'(NODE_COUNT))) begin
				mask[t] = 1'b1;
			end
		end
	end

	assign v_n = v_q[NW-1:0];
	assign root_n = root_q[NW-1:0];
	assign adj_row = adj_rvld_q ? adj_rd_q : '0;

	always_comb begin
		adj_re = 1'b1;
		case (ctrl.cmd)
			CMD_LOAD_RD: adj_raddr = node[idx_q];
			CMD_ROOT_PUSH: adj_raddr = root_n;
			CMD_PUSH: adj_raddr = v_n;
			CMD_POP_RD: adj_raddr = stk_rd_q;
			default: begin
				adj_raddr = node[idx_q];
				adj_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_raddr];
			adj_rvld_q <= row_vld_q[adj_raddr];
		end
		if (ctrl.cmd == CMD_LOAD_WR) begin
			adj_mem[node[idx_q]] <= adj_row | mask;
		end
		if (ctrl.cmd == CMD_ROOT_PUSH) begin
			stk_mem[0] <= root_n;
		end
		if (ctrl.cmd == CMD_PUSH) begin
			stk_mem[sp_q[NW-1:0]] <= v_n;
			nn_mem[u_q] <= v_q + VW'(1);
		end
		if (ctrl.cmd == CMD_RETIRE) begin
			stk_rd_q <= stk_mem[NW'(sp_q - VW'(2))];
		end
		if (ctrl.cmd == CMD_POP_RD) begin
			nn_rd_q <= nn_mem[stk_rd_q];
		end
		if (ctrl.cmd == CMD_CAPTURE) begin
			conn_q <= conn_in;
			last_q <= last_in;
		end
		case (ctrl.cmd)
			CMD_ROOT_PUSH: begin
				u_q <= root_n;
				v_q <= '0;
			end
			CMD_PUSH: begin
				u_q <= v_n;
				v_q <= '0;
			end
			CMD_POP_RD: u_q <= stk_rd_q;
			CMD_SCAN_NEXT: v_q <= v_q + VW'(1);
			CMD_ROW_LOAD: row_q <= adj_row;
			CMD_POP_LOAD: begin
				row_q <= adj_row;
				v_q <= nn_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			root_q <= '0;
			sp_q <= '0;
			grey_q <= '0;
			black_q <= '0;
			row_vld_q <= '0;
			found_q <= 1'b0;
			out_vld_q <= 1'b0;
			out_bit_q <= 1'b0;
		end else begin
			if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (ctrl.cmd)
				CMD_CAPTURE: begin
					idx_q <= '0;
					root_q <= '0;
					sp_q <= '0;
					found_q <= 1'b0;
				end
				CMD_SKIP_CONN: idx_q <= idx_q + IW'(1);
				CMD_LOAD_WR: begin
					idx_q <= idx_q + IW'(1);
					row_vld_q[node[idx_q]] <= 1'b1;
				end
				CMD_ROOT_NEXT: root_q <= root_q + VW'(1);
				CMD_ROOT_PUSH: begin
					grey_q[root_n] <= 1'b1;
					sp_q <= VW'(1);
				end
				CMD_PUSH: begin
					grey_q[v_n] <= 1'b1;
					sp_q <= sp_q + VW'(1);
				end
				CMD_RETIRE: begin
					grey_q[u_q] <= 1'b0;
					black_q[u_q] <= 1'b1;
					sp_q <= sp_q - VW'(1);
					if (sp_q == VW'(1)) begin
						root_q <= root_q + VW'(1);
					end
				end
				CMD_FOUND: found_q <= 1'b1;
				CMD_RESULT: begin
					out_vld_q <= 1'b1;
					out_bit_q <= found_q;
					grey_q <= '0;
					black_q <= '0;
					row_vld_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat.present = pres[idx_q];
		stat.last_conn = (idx_q == IW'(CONNECTORS_PER_SQUARE - 1));
		stat.last_sq = last_q;
		stat.root_done = (root_q == VW'(NODE_COUNT));
		stat.root_colored = grey_q[root_n] | black_q[root_n];
		stat.v_end = (v_q == VW'(NODE_COUNT));
		stat.edge_bit = row_q[v_n];
		stat.v_grey = grey_q[v_n];
		stat.v_white = !grey_q[v_n] && !black_q[v_n];
		stat.stack_full = (sp_q == VW'(NODE_COUNT));
		stat.sp_one = (sp_q == VW'(1));
		stat.out_busy = out_vld_q;
	end

	assign out_valid = out_vld_q;
	assign out_bit = out_bit_q;
endmodule

[hw/rtl/connector_graph_cycle_detector_unit.sv]
// A square is captured when accepted; each present connector is then merged into
// the adjacency memory by a read and a write (read-modify-write port), and each
// absent connector is skipped. On a last square the depth-first search scans one
// column per cycle while no node is pushed or popped, then registers the answer.
// Reset clears all control state and all node colors; the matrix reads as empty.
// Top level of the connector graph cycle detector; depends on cgcd_pkg, the channel
// interfaces, cgcd_ctrl, cgcd_dp and the assertion header.
`timescale 1ns / 1ps
`include "connector_graph_cycle_detector_unit_assert.svh"
module connector_graph_cycle_detector_unit import cgcd_pkg::*; #(
	parameter int unsigned NODE_COUNT            = 52,
	parameter int unsigned CONNECTORS_PER_SQUARE = 4
) (
	input logic clk,
	input logic arst_n,
	cgcd_sq_if.sink squares,
	cgcd_res_if.source results
);
	cgcd_ctrl_t ctrl;
	cgcd_status_t stat;
	logic [CONN_W-1:0] conn [CONNECTORS_PER_SQUARE];
	logic [CONN_W-1:0] codes [4];

	assign codes[0] = squares.connector_a;
	assign codes[1] = squares.connector_b;
	assign codes[2] = squares.connector_c;
	assign codes[3] = squares.connector_d;

	always_comb begin
		for (int k = 0; k < CONNECTORS_PER_SQUARE; k++) begin
			conn[k] = (k < 4) ? codes[k % 4] : '0;
		end
	end

	cgcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (squares.valid),
		.in_ready (squares.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	cgcd_dp #(
		.NODE_COUNT            (NODE_COUNT),
		.CONNECTORS_PER_SQUARE (CONNECTORS_PER_SQUARE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.conn_in   (conn),
		.last_in   (squares.last_square),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_bit   (results.has_cycle)
	);

	`CGCD_ASSERT_NXT(a_accept_blocks, squares.valid && squares.ready, !squares.ready)
	`CGCD_ASSERT_IMP(a_result_free, ctrl.cmd == CMD_RESULT, !stat.out_busy)
	`CGCD_ASSERT_IMP(a_push_room, ctrl.cmd == CMD_PUSH, !stat.stack_full)
endmodule
